### rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define OBT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication checked on every rising clock edge outside reset
`define OBT_ASSERT_IMP(label, ante, cons, msg) \
    `OBT_ASSERT(label, (ante) |-> (cons), msg)

`endif

### rtl/obt_pkg.sv
// package with types and constants of the stopwatch timer
`timescale 1ns / 1ps

package obt_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;
    localparam int COUNT_W   = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_MIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE  = 2'd3;

    localparam logic [CFG_W-1:0] RST_SHORT_MIN = 8'd5;
    localparam logic [CFG_W-1:0] RST_MODE_MIN  = 8'd50;
    localparam logic [CFG_W-1:0] RST_OFF_MIN   = 8'd200;
    localparam logic [CFG_W-1:0] RST_PRESCALE  = 8'd122;

    localparam logic [COUNT_W-1:0] TOP_COUNT = 7'd99;
    localparam logic [CFG_W-1:0]   TICK_MAX  = 8'd255;

    localparam logic FUNC_TICK     = 1'b0;
    localparam logic FUNC_OVERFLOW = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_RUN  = 3'b010,
        PH_STOP = 3'b100
    } t_phase;

    typedef struct packed {
        logic func;
        logic button;
    } t_item;

endpackage

### rtl/obt_ifs.sv
// handshake channel interfaces for input and result beats
`timescale 1ns / 1ps

interface obt_in_if;
    logic valid;
    logic ready;
    logic func;
    logic button;

    modport source (output valid, output func, output button, input ready);
    modport sink (input valid, input func, input button, output ready);
endinterface

interface obt_out_if;
    import obt_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] shown_value;
    logic               timer_mode;
    logic               running;
    logic               stopped;
    logic               pressing;
    logic               power_down;

    modport source (
        output valid, output shown_value, output timer_mode, output running,
        output stopped, output pressing, output power_down, input ready
    );
    modport sink (
        input valid, input shown_value, input timer_mode, input running,
        input stopped, input pressing, input power_down, output ready
    );
endinterface

### rtl/obt_in_stage.sv
// input register stage holding one accepted beat
`timescale 1ns / 1ps

module obt_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    obt_in_if.sink        i_in,
    input  logic          i_take,
    output logic          o_valid,
    output obt_pkg::t_item o_item
);
    import obt_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;

    assign i_in.ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (i_in.valid && i_in.ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.func   <= i_in.func;
            r_item.button <= i_in.button;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/obt_core.sv
// timer state update, configuration registers and result register
`timescale 1ns / 1ps

module obt_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  obt_pkg::t_item                i_item,
    output logic                          o_take,
    input  logic                          i_cfg_we,
    input  logic [obt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [obt_pkg::CFG_W-1:0]     i_cfg_data,
    obt_out_if.source                     o_out
);
    import obt_pkg::*;

    logic [CFG_W-1:0] r_short_min;
    logic [CFG_W-1:0] r_mode_min;
    logic [CFG_W-1:0] r_off_min;
    logic [CFG_W-1:0] r_prescale_top;

    logic               r_mode;
    t_phase             r_phase;
    logic [COUNT_W-1:0] r_count;
    logic [CFG_W-1:0]   r_prescale;
    logic [CFG_W-1:0]   r_ticks;
    logic               r_press;
    logic               r_halted;

    logic               n_mode;
    t_phase             n_phase;
    logic [COUNT_W-1:0] n_count;
    logic [CFG_W-1:0]   n_prescale;
    logic [CFG_W-1:0]   n_ticks;
    logic               n_press;
    logic               n_halted;

    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_shown;
    logic               r_out_mode;
    logic               r_out_running;
    logic               r_out_stopped;
    logic               r_out_pressing;
    logic               r_out_power_down;
    logic               n_out_valid;

    logic take;
    logic action;
    logic do_run;

    assign take   = i_valid && (!r_out_valid || o_out.ready);
    assign o_take = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_min    <= RST_SHORT_MIN;
            r_mode_min     <= RST_MODE_MIN;
            r_off_min      <= RST_OFF_MIN;
            r_prescale_top <= RST_PRESCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SHORT_MIN: r_short_min    <= i_cfg_data;
                CFG_MODE_MIN:  r_mode_min     <= i_cfg_data;
                CFG_OFF_MIN:   r_off_min      <= i_cfg_data;
                CFG_PRESCALE:  r_prescale_top <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_phase    = r_phase;
        n_count    = r_count;
        n_prescale = r_prescale;
        n_ticks    = r_ticks;
        n_press    = r_press;
        n_halted   = r_halted;
        action     = 1'b0;
        do_run     = 1'b0;
        if (take && !r_halted) begin
            if (i_item.func == FUNC_OVERFLOW) begin
                if (r_prescale == r_prescale_top) begin
                    n_prescale = '0;
                    if (r_phase == PH_RUN && r_count < TOP_COUNT) begin
                        n_count = r_count + 7'd1;
                    end
                end else begin
                    n_prescale = r_prescale + 8'd1;
                end
            end else begin
                do_run = 1'b1;
                if (r_press) begin
                    if (i_item.button) begin
                        do_run = 1'b0;
                        if (r_ticks != TICK_MAX) begin
                            n_ticks = r_ticks + 8'd1;
                        end
                    end else begin
                        n_press = 1'b0;
                        if (r_ticks > r_off_min) begin
                            n_halted = 1'b1;
                            do_run   = 1'b0;
                        end else if (r_ticks > r_mode_min) begin
                            n_mode  = !r_mode;
                            n_phase = PH_IDLE;
                            n_count = '0;
                        end else if (r_ticks > r_short_min) begin
                            action = 1'b1;
                        end
                    end
                end else if (i_item.button) begin
                    n_press = 1'b1;
                    n_ticks = '0;
                    do_run  = 1'b0;
                end
                // run phase stepping after the press is classified
                if (do_run) begin
                    if (action && n_phase == PH_STOP) begin
                        n_count = '0;
                    end
                    if (action ||
                        (!n_mode && n_count == TOP_COUNT && n_phase == PH_RUN)) begin
                        case (n_phase)
                            PH_IDLE: begin
                                n_prescale = '0;
                                n_phase    = PH_RUN;
                            end
                            PH_RUN:  n_phase = PH_STOP;
                            PH_STOP: n_phase = PH_IDLE;
                            default: n_phase = PH_IDLE;
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_phase    <= PH_IDLE;
            r_count    <= '0;
            r_prescale <= '0;
            r_ticks    <= '0;
            r_press    <= 1'b0;
            r_halted   <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_prescale <= n_prescale;
            r_ticks    <= n_ticks;
            r_press    <= n_press;
            r_halted   <= n_halted;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (take) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_shown      <= n_mode ? (TOP_COUNT - n_count) : n_count;
            r_out_mode       <= n_mode;
            r_out_running    <= (n_phase == PH_RUN);
            r_out_stopped    <= (n_phase == PH_STOP);
            r_out_pressing   <= n_press;
            r_out_power_down <= n_halted;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.shown_value = r_out_shown;
    assign o_out.timer_mode  = r_out_mode;
    assign o_out.running     = r_out_running;
    assign o_out.stopped     = r_out_stopped;
    assign o_out.pressing    = r_out_pressing;
    assign o_out.power_down  = r_out_power_down;

endmodule

### rtl/one_button_stopwatch_timer.sv
// top level of the one-button stopwatch and countdown timer
//
// usage:
// - i_in carries one event per beat: func 0 is a display tick with the
//   button level, func 1 is a timer overflow that feeds the prescaler
// - o_out carries one status beat per input beat: shown value, mode,
//   running, stopped, pressing and power-down flags after that event
// - i_cfg_we / i_cfg_idx / i_cfg_data write the four 8-bit thresholds
//   (short press, mode press, off press, prescale top) while idle
// - an input beat passes the input register, then the state update
//   feeding the result register
// - throughput is one beat per cycle unless o_out stalls; the single
//   state update path from input to result register sets that figure
// - a stalled receiver holds the result register; the input register
//   still takes one more beat, then i_in.ready drops until o_out drains
// - reset clears the state to stopwatch, idle, count zero, no press,
//   not halted, and loads the default thresholds
// - after a long press every event is ignored until reset, results still
//   report the held state
`timescale 1ns / 1ps

module one_button_stopwatch_timer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    obt_in_if.sink                        i_in,
    obt_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [obt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [obt_pkg::CFG_W-1:0]     i_cfg_data
);
    import obt_pkg::*;

    `include "assert_macros.svh"

    logic  stage_valid;
    t_item stage_item;
    logic  stage_take;

    obt_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (stage_take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    obt_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (stage_valid),
        .i_item     (stage_item),
        .o_take     (stage_take),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out      (o_out)
    );

    `OBT_ASSERT_IMP(a_phase_excl, o_out.valid, !(o_out.running && o_out.stopped), "run and stop both set")
    `OBT_ASSERT_IMP(a_shown_range, o_out.valid, o_out.shown_value <= TOP_COUNT, "shown value above 99")
    `OBT_ASSERT_IMP(a_ready_empty, !o_out.valid, i_in.ready, "input stalled with empty result")
    `OBT_ASSERT_IMP(a_halt_sticky, $past(i_rst_n) && $past(o_out.valid && o_out.power_down) && o_out.valid, o_out.power_down, "power down dropped without reset")

endmodule

### dv/testbench.sv
// self-checking testbench for the one-button stopwatch and countdown timer
`timescale 1ns / 1ps

module testbench;
    import obt_pkg::*;

    localparam int N_SETTINGS  = 8;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [COUNT_W-1:0] shown;
        logic               mode;
        logic               running;
        logic               stopped;
        logic               pressing;
        logic               power_down;
    } t_status;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    obt_in_if  in_ch ();
    obt_out_if out_ch ();

    one_button_stopwatch_timer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // predicted block state and thresholds
    logic [CFG_W-1:0]   thr_short;
    logic [CFG_W-1:0]   thr_mode;
    logic [CFG_W-1:0]   thr_off;
    logic [CFG_W-1:0]   thr_prescale;
    logic               mdl_mode;
    t_phase             mdl_phase;
    logic [COUNT_W-1:0] mdl_count;
    logic [CFG_W-1:0]   mdl_prescale;
    logic [CFG_W-1:0]   mdl_ticks;
    logic               mdl_pressing;
    logic               mdl_halted;

    t_item   event_pending [$];
    t_status status_expected [$];
    t_item   next_beat;
    t_status want;

    logic [31:0] phase_cfg [N_SETTINGS];
    bit  stall_on;
    int  stall_odds;
    int  src_hold;
    int  sink_hold;
    int  cycle_count = 0;
    int  n_errors;
    int  n_queued;
    int  n_events;
    int  n_overflows;
    int  n_results;
    int  n_starts;
    int  n_auto_stops;
    int  n_mode_flips;
    int  n_power_down;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d status beats still expected", $time,
                     status_expected.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic predict_status(input logic func, input logic button);
        logic    do_run;
        logic    act;
        t_status s;
        do_run = 1'b0;
        act    = 1'b0;
        n_events++;
        if (!mdl_halted) begin
            if (func == FUNC_OVERFLOW) begin
                n_overflows++;
                if (mdl_prescale == thr_prescale) begin
                    if (mdl_phase == PH_RUN && mdl_count < TOP_COUNT)
                        mdl_count = mdl_count + 7'd1;
                    mdl_prescale = '0;
                end else begin
                    mdl_prescale = mdl_prescale + 8'd1;
                end
            end else if (mdl_pressing) begin
                if (button) begin
                    if (mdl_ticks != TICK_MAX)
                        mdl_ticks = mdl_ticks + 8'd1;
                end else begin
                    mdl_pressing = 1'b0;
                    if (mdl_ticks > thr_off) begin
                        mdl_halted = 1'b1;
                        n_power_down++;
                    end else if (mdl_ticks > thr_mode) begin
                        mdl_mode  = ~mdl_mode;
                        mdl_phase = PH_IDLE;
                        mdl_count = '0;
                        n_mode_flips++;
                    end else begin
                        do_run = 1'b1;
                        act    = (mdl_ticks > thr_short);
                    end
                end
            end else if (button) begin
                mdl_pressing = 1'b1;
                mdl_ticks    = '0;
            end else begin
                do_run = 1'b1;
            end
        end
        if (do_run) begin
            if (act && mdl_phase == PH_STOP)
                mdl_count = '0;
            if (!act && !mdl_mode && mdl_count == TOP_COUNT && mdl_phase == PH_RUN)
                n_auto_stops++;
            if (act || (!mdl_mode && mdl_count == TOP_COUNT && mdl_phase == PH_RUN)) begin
                case (mdl_phase)
                    PH_IDLE: begin
                        mdl_prescale = '0;
                        mdl_phase    = PH_RUN;
                        n_starts++;
                    end
                    PH_RUN: begin
                        mdl_phase = PH_STOP;
                    end
                    default: begin
                        mdl_phase = PH_IDLE;
                    end
                endcase
            end
        end
        s.shown      = mdl_mode ? TOP_COUNT - mdl_count : mdl_count;
        s.mode       = mdl_mode;
        s.running    = (mdl_phase == PH_RUN);
        s.stopped    = (mdl_phase == PH_STOP);
        s.pressing   = mdl_pressing;
        s.power_down = mdl_halted;
        status_expected.push_back(s);
    endtask

    task automatic compare_field(input string what, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what,
                     exp_v, act_v);
        end
    endtask

    // input driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            src_hold = 0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                predict_status(in_ch.func, in_ch.button);
            if (!in_ch.valid || in_ch.ready) begin
                if (src_hold > 0) begin
                    src_hold--;
                    in_ch.valid <= 1'b0;
                end else if (stall_on && $urandom_range(0, stall_odds) == 0) begin
                    src_hold = $urandom_range(0, 15);
                    in_ch.valid <= 1'b0;
                end else if (event_pending.size() != 0) begin
                    next_beat = event_pending.pop_front();
                    in_ch.valid  <= 1'b1;
                    in_ch.func   <= next_beat.func;
                    in_ch.button <= next_beat.button;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // status monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            sink_hold = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (status_expected.size() == 0) begin
                    n_errors++;
                    $display("%0t: status beat with nothing expected, actual shown %0d",
                             $time, out_ch.shown_value);
                end else begin
                    want = status_expected.pop_front();
                    compare_field("shown_value", 8'(want.shown), 8'(out_ch.shown_value));
                    compare_field("timer_mode", 8'(want.mode), 8'(out_ch.timer_mode));
                    compare_field("running", 8'(want.running), 8'(out_ch.running));
                    compare_field("stopped", 8'(want.stopped), 8'(out_ch.stopped));
                    compare_field("pressing", 8'(want.pressing), 8'(out_ch.pressing));
                    compare_field("power_down", 8'(want.power_down),
                                  8'(out_ch.power_down));
                end
            end
            if (sink_hold > 0) begin
                sink_hold--;
                out_ch.ready <= 1'b0;
            end else if (stall_on && $urandom_range(0, stall_odds) == 0) begin
                sink_hold = $urandom_range(0, 15);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic queue_event(input logic func, input logic button);
        t_item it;
        it.func   = func;
        it.button = button;
        event_pending.push_back(it);
        n_queued++;
    endtask

    // n pressed ticks then a release, overflows mixed in
    task automatic queue_press(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                queue_event(FUNC_OVERFLOW, 1'($urandom_range(0, 1)));
            queue_event(FUNC_TICK, 1'b1);
        end
        queue_event(FUNC_TICK, 1'b0);
    endtask

    task automatic queue_random_events(input int budget);
        int stop_at;
        int t;
        int cap;
        int k;
        stop_at = n_queued + budget;
        while (n_queued < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    cap = (thr_off == TICK_MAX) ? 300 : int'(thr_off);
                    case ($urandom_range(0, 5))
                        0:       t = int'(thr_short);
                        1:       t = int'(thr_short) + 1;
                        2:       t = int'(thr_mode);
                        3:       t = int'(thr_mode) + 1;
                        default: t = $urandom_range(0, 12);
                    endcase
                    if (t > 64 && $urandom_range(0, 7) != 0)
                        t = $urandom_range(0, 64);
                    if (t > cap)
                        t = cap;
                    queue_press(t + 1);
                end
                4, 5, 6: begin
                    k = (int'(thr_prescale) + 1) * 40;
                    if (k > 250)
                        k = 250;
                    k = $urandom_range(1, k);
                    repeat (k) queue_event(FUNC_OVERFLOW, 1'($urandom_range(0, 1)));
                end
                7: begin
                    repeat ($urandom_range(1, 4)) queue_event(FUNC_TICK, 1'b0);
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0: queue_event(FUNC_OVERFLOW, 1'($urandom_range(0, 1)));
                        1: queue_event(FUNC_TICK, 1'b0);
                        default: queue_press(1);
                    endcase
                end
            endcase
        end
    endtask

    task automatic write_timer_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_SHORT_MIN: thr_short    = data;
            CFG_MODE_MIN:  thr_mode     = data;
            CFG_OFF_MIN:   thr_off      = data;
            CFG_PRESCALE:  thr_prescale = data;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (event_pending.size() != 0 || in_ch.valid || status_expected.size() != 0);
    endtask

    initial begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_SHORT_MIN;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.func   = FUNC_TICK;
        in_ch.button = 1'b0;
        out_ch.ready = 1'b0;
        stall_on     = 1'b1;
        stall_odds   = 8;
        n_errors     = 0;
        n_queued     = 0;
        n_events     = 0;
        n_overflows  = 0;
        n_results    = 0;
        n_starts     = 0;
        n_auto_stops = 0;
        n_mode_flips = 0;
        n_power_down = 0;
        thr_short    = RST_SHORT_MIN;
        thr_mode     = RST_MODE_MIN;
        thr_off      = RST_OFF_MIN;
        thr_prescale = RST_PRESCALE;
        mdl_mode     = 1'b0;
        mdl_phase    = PH_IDLE;
        mdl_count    = '0;
        mdl_prescale = '0;
        mdl_ticks    = '0;
        mdl_pressing = 1'b0;
        mdl_halted   = 1'b0;
        // short, mode, off, prescale top
        phase_cfg = '{
            {8'd1,   8'd3,   8'd255, 8'd1},
            {8'd5,   8'd50,  8'd200, 8'd122},
            {8'd0,   8'd255, 8'd255, 8'd0},
            {8'd20,  8'd8,   8'd255, 8'd3},
            {8'd3,   8'd10,  8'd30,  8'd2},
            {8'd255, 8'd0,   8'd255, 8'd255},
            {8'd2,   8'd6,   8'd12,  8'd1},
            {8'd0,   8'd0,   8'd0,   8'd0}
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < N_SETTINGS; k++) begin
            write_timer_reg(CFG_SHORT_MIN, phase_cfg[k][31:24]);
            write_timer_reg(CFG_MODE_MIN, phase_cfg[k][23:16]);
            write_timer_reg(CFG_OFF_MIN, phase_cfg[k][15:8]);
            write_timer_reg(CFG_PRESCALE, phase_cfg[k][7:0]);
            @(posedge clk);
            cfg_we <= 1'b0;
            stall_on   = (k != 3) && (k != N_SETTINGS - 1);
            stall_odds = $urandom_range(3, 24);
            if (k == 0) begin
                // button on overflow ignored, idle tick, start, count, stop, tap,
                // clear, mode switch
                queue_event(FUNC_OVERFLOW, 1'b1);
                queue_event(FUNC_OVERFLOW, 1'b0);
                queue_event(FUNC_TICK, 1'b0);
                queue_press(3);
                repeat (2) queue_event(FUNC_OVERFLOW, 1'b0);
                queue_press(3);
                queue_press(1);
                queue_press(3);
                queue_press(5);
            end else if (k == N_SETTINGS - 1) begin
                // any measured press now powers down, then everything is ignored
                queue_random_events(40);
                queue_press($urandom_range(2, 300));
                repeat (30) queue_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                queue_random_events(330);
            end
            wait_drained();
            repeat (4) @(posedge clk);
        end

        $display("ran %0d events (%0d overflows) over %0d threshold settings, %0d beats checked",
                 n_events, n_overflows, N_SETTINGS, n_results);
        $display("starts %0d, auto stops at top %0d, mode switches %0d, power downs %0d",
                 n_starts, n_auto_stops, n_mode_flips, n_power_down);
        if (n_errors == 0 && status_expected.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
